// ----- design/plr_pkg.sv -----
// shared types, widths and operation codes of the polyline arc-length resampler
// used by plr_unit and polyline_arc_length_resampler_top; depends on nothing
package plr_pkg;

	// default depth of the point store
	localparam int MAX_POINTS_DEF = 64;

	// coordinate and arithmetic widths
	localparam int COORD_W = 32;
	localparam int DIFF_W  = 33;
	localparam int LEN_W   = 34;
	localparam int WIDE    = 68;
	localparam int REM_W   = 38;
	localparam int STEP_W  = 7;
	localparam int PNT_W   = 96;

	// interior point limit
	localparam logic [5:0] MAX_INTERIOR = 6'd62;

	// status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_SHORT = 2'd1;
	localparam logic [1:0] ST_OVF   = 2'd2;

	// shared unit operations
	localparam logic [1:0] OP_MUL  = 2'd0;
	localparam logic [1:0] OP_DIV  = 2'd1;
	localparam logic [1:0] OP_SQRT = 2'd2;

	// request from the sequencer to the shared unit
	typedef struct packed {
		logic       start;
		logic [1:0] op;
	} unit_req_t;

endpackage

// ----- design/plr_unit.sv -----
// shared iterative arithmetic unit: shift-add multiply, restoring divide, digit square root
// one bit (two radicand bits for the root) per cycle; depends on plr_pkg
module plr_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  plr_pkg::unit_req_t              req,
	input  logic [plr_pkg::WIDE-1:0]        opa,
	input  logic [plr_pkg::LEN_W-1:0]       opb,
	output logic                            done,
	output logic [plr_pkg::WIDE-1:0]        res
);

	logic [1:0]                    op_q;
	logic                          busy_q;
	logic                          done_q;
	logic [plr_pkg::STEP_W-1:0]    cnt_q;
	logic [plr_pkg::WIDE-1:0]      x_q;
	logic [plr_pkg::LEN_W-1:0]     y_q;
	logic [plr_pkg::WIDE-1:0]      acc_q;
	logic [plr_pkg::REM_W-1:0]     rem_q;
	logic [plr_pkg::LEN_W-1:0]     root_q;

	logic [plr_pkg::REM_W-1:0]     rsh_div;
	logic [plr_pkg::REM_W-1:0]     rsh_sq;
	logic [plr_pkg::REM_W-1:0]     trial_sq;
	logic [plr_pkg::REM_W-1:0]     den_ext;
	logic [plr_pkg::STEP_W-1:0]    steps;

	// shifted remainders and trial values of one step
	always_comb begin
		rsh_div  = {rem_q[plr_pkg::REM_W-2:0], x_q[plr_pkg::WIDE-1]};
		rsh_sq   = {rem_q[plr_pkg::REM_W-3:0], x_q[plr_pkg::WIDE-1 -: 2]};
		trial_sq = {2'b00, root_q, 2'b01};
		den_ext  = {4'd0, y_q};
		case (req.op)
			plr_pkg::OP_MUL:  steps = plr_pkg::STEP_W'(plr_pkg::LEN_W - 1);
			plr_pkg::OP_DIV:  steps = plr_pkg::STEP_W'(plr_pkg::WIDE - 1);
			plr_pkg::OP_SQRT: steps = plr_pkg::STEP_W'(plr_pkg::WIDE / 2 - 1);
			default:          steps = plr_pkg::STEP_W'(plr_pkg::LEN_W - 1);
		endcase
	end

	// iteration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q   <= plr_pkg::OP_MUL;
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			x_q    <= '0;
			y_q    <= '0;
			acc_q  <= '0;
			rem_q  <= '0;
			root_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				op_q   <= req.op;
				busy_q <= 1'b1;
				cnt_q  <= steps;
				x_q    <= opa;
				y_q    <= opb;
				acc_q  <= '0;
				rem_q  <= '0;
				root_q <= '0;
			end else if (busy_q) begin
				case (op_q)
					plr_pkg::OP_MUL: begin
						if (y_q[0])
							acc_q <= acc_q + x_q;
						x_q <= {x_q[plr_pkg::WIDE-2:0], 1'b0};
						y_q <= {1'b0, y_q[plr_pkg::LEN_W-1:1]};
					end
					plr_pkg::OP_DIV: begin
						if (rsh_div >= den_ext) begin
							rem_q <= rsh_div - den_ext;
							x_q   <= {x_q[plr_pkg::WIDE-2:0], 1'b1};
						end else begin
							rem_q <= rsh_div;
							x_q   <= {x_q[plr_pkg::WIDE-2:0], 1'b0};
						end
					end
					plr_pkg::OP_SQRT: begin
						if (rsh_sq >= trial_sq) begin
							rem_q  <= rsh_sq - trial_sq;
							root_q <= {root_q[plr_pkg::LEN_W-2:0], 1'b1};
						end else begin
							rem_q  <= rsh_sq;
							root_q <= {root_q[plr_pkg::LEN_W-2:0], 1'b0};
						end
						x_q <= {x_q[plr_pkg::WIDE-3:0], 2'b00};
					end
					default: begin
						busy_q <= 1'b0;
					end
				endcase
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// result select
	always_comb begin
		case (op_q)
			plr_pkg::OP_MUL:  res = acc_q;
			plr_pkg::OP_DIV:  res = x_q;
			plr_pkg::OP_SQRT: res = {{(plr_pkg::WIDE-plr_pkg::LEN_W){1'b0}}, root_q};
			default:          res = acc_q;
		endcase
	end

	assign done = done_q;

`ifndef SYNTH
	// a new operation only starts on an idle unit
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q)
		else $error("unit started while busy");

	// completion follows a busy iteration
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("unit done without work");
`endif

endmodule

// ----- design/polyline_arc_length_resampler_top.sv -----
// top level of the polyline arc-length resampler: point store, segment length store,
// run sequencer and output register; depends on plr_pkg and plr_unit
//
// Points stream in on s_axis, one transaction per cycle; the point with tlast set
// starts a run and the input stays not ready until the run's last result is loaded into the output register.
// A run sums segment lengths and emits the first point, interior_points (at most 62) equally
// spaced points and the last point on m_axis; a run of fewer than two points emits one
// zero sample with the short status instead. All arithmetic goes through one shared
// iterative unit taking one bit per cycle, which sets the run time: each stored segment
// takes three squarings and a root, and each interior point a multiply and divide for
// the target, a walk over the segments, and a multiply and divide for each coordinate.
// No clearing pass is needed after reset.
module polyline_arc_length_resampler_top #(
	parameter int MAX_POINTS = plr_pkg::MAX_POINTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [5:0]  cfg_wdata,       // interior_points
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [95:0] s_axis_tdata,    // pos_x, pos_y, pos_z
	input  logic        s_axis_tlast,    // final_point
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [95:0] m_axis_tdata,    // out_x, out_y, out_z
	output logic        m_axis_tlast,    // end_of_run
	output logic [1:0]  m_axis_tuser     // status
);

	localparam int PTR_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CNT_W = $clog2(MAX_POINTS + 1);
	localparam int CMP_W = CNT_W + 1;
	localparam int TOT_W = plr_pkg::LEN_W + PTR_W;
	localparam int CW    = plr_pkg::COORD_W;
	localparam int DW    = plr_pkg::DIFF_W;

	localparam logic [4:0] S_IDLE   = 5'd0;
	localparam logic [4:0] S_CHK    = 5'd1;
	localparam logic [4:0] S_RDA    = 5'd2;
	localparam logic [4:0] S_RDB    = 5'd3;
	localparam logic [4:0] S_RDC    = 5'd4;
	localparam logic [4:0] S_SQ_GO  = 5'd5;
	localparam logic [4:0] S_SQ_WT  = 5'd6;
	localparam logic [4:0] S_RT_GO  = 5'd7;
	localparam logic [4:0] S_RT_WT  = 5'd8;
	localparam logic [4:0] S_END_RD = 5'd9;
	localparam logic [4:0] S_END_LD = 5'd10;
	localparam logic [4:0] S_EMIT   = 5'd11;
	localparam logic [4:0] S_T_MGO  = 5'd12;
	localparam logic [4:0] S_T_MWT  = 5'd13;
	localparam logic [4:0] S_T_DGO  = 5'd14;
	localparam logic [4:0] S_T_DWT  = 5'd15;
	localparam logic [4:0] S_W_RD   = 5'd16;
	localparam logic [4:0] S_W_CHK  = 5'd17;
	localparam logic [4:0] S_PL_MGO = 5'd18;
	localparam logic [4:0] S_PL_MWT = 5'd19;
	localparam logic [4:0] S_PL_DGO = 5'd20;
	localparam logic [4:0] S_PL_DWT = 5'd21;

	localparam logic [2:0] PH_SEG   = 3'd0;
	localparam logic [2:0] PH_FIRST = 3'd1;
	localparam logic [2:0] PH_INT   = 3'd2;
	localparam logic [2:0] PH_LAST  = 3'd3;
	localparam logic [2:0] PH_ERR   = 3'd4;

	logic [4:0]                  state_q;
	logic [2:0]                  ph_q;
	logic [CNT_W-1:0]            count_q;
	logic                        ovf_q;
	logic [5:0]                  interior_q;
	logic [1:0]                  status_q;
	logic [PTR_W-1:0]            seg_q;
	logic [1:0]                  k_q;
	logic [5:0]                  j_q;
	logic [TOT_W-1:0]            total_q;
	logic [TOT_W-1:0]            sofar_q;
	logic [TOT_W-1:0]            t_q;
	logic [plr_pkg::LEN_W-1:0]   len_q;
	logic [plr_pkg::LEN_W-1:0]   ib_q;
	logic [plr_pkg::WIDE-1:0]    sq_q;
	logic [plr_pkg::WIDE-1:0]    prod_q;
	logic signed [CW-1:0]        pa_q [3];
	logic signed [DW-1:0]        d_q  [3];
	logic [CW-1:0]               e_q  [3];
	logic                        elast_q;
	logic                        out_valid_q;
	logic [95:0]                 out_data_q;
	logic                        out_last_q;
	logic [1:0]                  out_status_q;

	logic [plr_pkg::PNT_W-1:0]   pt_mem [MAX_POINTS];
	logic [plr_pkg::PNT_W-1:0]   pt_rd_q;
	logic [plr_pkg::LEN_W-1:0]   sl_mem [MAX_POINTS];
	logic [plr_pkg::LEN_W-1:0]   sl_rd_q;

	logic                        in_fire;
	logic                        pt_we;
	logic                        pt_re;
	logic [PTR_W-1:0]            pt_raddr;
	logic                        sl_we;
	logic                        sl_re;
	logic [5:0]                  newp;
	logic [DW-1:0]               mag_k;
	logic                        walk_more;
	logic                        last_seg;
	logic [TOT_W-1:0]            gap;
	logic [TOT_W-1:0]            len_ext;
	logic [CW-1:0]               quo;
	logic [CW-1:0]               placed;

	plr_pkg::unit_req_t          ureq;
	logic [plr_pkg::WIDE-1:0]    uopa;
	logic [plr_pkg::LEN_W-1:0]   uopb;
	logic                        udone;
	logic [plr_pkg::WIDE-1:0]    ures;

	plr_unit u_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (ureq),
		.opa    (uopa),
		.opb    (uopb),
		.done   (udone),
		.res    (ures)
	);

	// input handshake and store write
	assign s_axis_tready = (state_q == S_IDLE);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign pt_we         = in_fire && (count_q < CNT_W'(MAX_POINTS));

	// derived walk values
	always_comb begin
		newp      = (interior_q > plr_pkg::MAX_INTERIOR) ? plr_pkg::MAX_INTERIOR : interior_q;
		mag_k     = d_q[k_q][DW-1] ? DW'(-d_q[k_q]) : DW'(d_q[k_q]);
		walk_more = (CMP_W'(seg_q) + CMP_W'(2)) < CMP_W'(count_q);
		last_seg  = (CMP_W'(seg_q) + CMP_W'(2)) == CMP_W'(count_q);
		gap       = t_q - sofar_q;
		len_ext   = TOT_W'(sl_rd_q);
		quo       = ures[CW-1:0];
		placed    = d_q[k_q][DW-1] ? CW'(pa_q[k_q]) - quo : CW'(pa_q[k_q]) + quo;
	end

	// memory read control
	always_comb begin
		pt_re    = 1'b0;
		pt_raddr = seg_q;
		sl_re    = 1'b0;
		sl_we    = (state_q == S_RT_WT) && udone;
		case (state_q)
			S_RDA: begin
				pt_re = 1'b1;
			end
			S_RDB: begin
				pt_re    = 1'b1;
				pt_raddr = seg_q + 1'b1;
			end
			S_END_RD: begin
				pt_re    = 1'b1;
				pt_raddr = (ph_q == PH_FIRST) ? '0 : PTR_W'(count_q - 1'b1);
			end
			S_W_RD: begin
				sl_re = 1'b1;
			end
			default: begin
				pt_re = 1'b0;
			end
		endcase
	end

	// shared unit requests
	always_comb begin
		ureq.start = 1'b0;
		ureq.op    = plr_pkg::OP_MUL;
		uopa       = plr_pkg::WIDE'(mag_k);
		uopb       = plr_pkg::LEN_W'(mag_k);
		case (state_q)
			S_SQ_GO: begin
				ureq.start = 1'b1;
			end
			S_RT_GO: begin
				ureq.start = 1'b1;
				ureq.op    = plr_pkg::OP_SQRT;
				uopa       = sq_q;
			end
			S_T_MGO: begin
				ureq.start = 1'b1;
				uopa       = plr_pkg::WIDE'(total_q);
				uopb       = plr_pkg::LEN_W'(j_q);
			end
			S_T_DGO: begin
				ureq.start = 1'b1;
				ureq.op    = plr_pkg::OP_DIV;
				uopa       = prod_q;
				uopb       = plr_pkg::LEN_W'({1'b0, newp} + 7'd1);
			end
			S_PL_MGO: begin
				ureq.start = (len_q != '0);
				uopb       = ib_q;
			end
			S_PL_DGO: begin
				ureq.start = 1'b1;
				ureq.op    = plr_pkg::OP_DIV;
				uopa       = prod_q;
				uopb       = len_q;
			end
			default: begin
				ureq.start = 1'b0;
			end
		endcase
	end

	// point and segment length stores
	always_ff @(posedge clk) begin
		if (pt_we)
			pt_mem[count_q[PTR_W-1:0]] <= s_axis_tdata;
		if (pt_re)
			pt_rd_q <= pt_mem[pt_raddr];
		if (sl_we)
			sl_mem[seg_q] <= ures[plr_pkg::LEN_W-1:0];
		if (sl_re)
			sl_rd_q <= sl_mem[seg_q];
	end

	// run sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			ph_q       <= PH_SEG;
			count_q    <= '0;
			ovf_q      <= 1'b0;
			interior_q <= 6'd1;
			status_q   <= plr_pkg::ST_OK;
			seg_q      <= '0;
			k_q        <= '0;
			j_q        <= '0;
			total_q    <= '0;
			sofar_q    <= '0;
			t_q        <= '0;
			len_q      <= '0;
			ib_q       <= '0;
			sq_q       <= '0;
			prod_q     <= '0;
			pa_q       <= '{default: '0};
			d_q        <= '{default: '0};
			e_q        <= '{default: '0};
			elast_q    <= 1'b0;
		end else begin
			if (cfg_we)
				interior_q <= cfg_wdata;
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						if (pt_we)
							count_q <= count_q + 1'b1;
						else
							ovf_q <= 1'b1;
						if (s_axis_tlast)
							state_q <= S_CHK;
					end
				end
				S_CHK: begin
					if (count_q < CNT_W'(2)) begin
						e_q      <= '{default: '0};
						elast_q  <= 1'b1;
						status_q <= plr_pkg::ST_SHORT;
						ph_q     <= PH_ERR;
						state_q  <= S_EMIT;
					end else begin
						status_q <= ovf_q ? plr_pkg::ST_OVF : plr_pkg::ST_OK;
						seg_q    <= '0;
						total_q  <= '0;
						ph_q     <= PH_SEG;
						state_q  <= S_RDA;
					end
				end
				S_RDA: begin
					state_q <= S_RDB;
				end
				S_RDB: begin
					pa_q[0] <= pt_rd_q[CW-1:0];
					pa_q[1] <= pt_rd_q[2*CW-1:CW];
					pa_q[2] <= pt_rd_q[3*CW-1:2*CW];
					state_q <= S_RDC;
				end
				S_RDC: begin
					d_q[0]  <= DW'($signed(pt_rd_q[CW-1:0])) - DW'(pa_q[0]);
					d_q[1]  <= DW'($signed(pt_rd_q[2*CW-1:CW])) - DW'(pa_q[1]);
					d_q[2]  <= DW'($signed(pt_rd_q[3*CW-1:2*CW])) - DW'(pa_q[2]);
					k_q     <= '0;
					sq_q    <= '0;
					state_q <= (ph_q == PH_SEG) ? S_SQ_GO : S_PL_MGO;
				end
				// sum of squares then root
				S_SQ_GO: begin
					state_q <= S_SQ_WT;
				end
				S_SQ_WT: begin
					if (udone) begin
						sq_q <= sq_q + ures;
						if (k_q == 2'd2) begin
							state_q <= S_RT_GO;
						end else begin
							k_q     <= k_q + 1'b1;
							state_q <= S_SQ_GO;
						end
					end
				end
				S_RT_GO: begin
					state_q <= S_RT_WT;
				end
				S_RT_WT: begin
					if (udone) begin
						total_q <= total_q + TOT_W'(ures[plr_pkg::LEN_W-1:0]);
						if (last_seg) begin
							ph_q    <= PH_FIRST;
							state_q <= S_END_RD;
						end else begin
							seg_q   <= seg_q + 1'b1;
							state_q <= S_RDA;
						end
					end
				end
				// endpoint emission
				S_END_RD: begin
					state_q <= S_END_LD;
				end
				S_END_LD: begin
					e_q[0]  <= pt_rd_q[CW-1:0];
					e_q[1]  <= pt_rd_q[2*CW-1:CW];
					e_q[2]  <= pt_rd_q[3*CW-1:2*CW];
					elast_q <= (ph_q == PH_LAST);
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (!out_valid_q) begin
						case (ph_q)
							PH_FIRST: begin
								seg_q   <= '0;
								sofar_q <= '0;
								j_q     <= 6'd1;
								if (newp == '0) begin
									ph_q    <= PH_LAST;
									state_q <= S_END_RD;
								end else begin
									ph_q    <= PH_INT;
									state_q <= S_T_MGO;
								end
							end
							PH_INT: begin
								if (j_q == newp) begin
									ph_q    <= PH_LAST;
									state_q <= S_END_RD;
								end else begin
									j_q     <= j_q + 1'b1;
									state_q <= S_T_MGO;
								end
							end
							default: begin
								count_q <= '0;
								ovf_q   <= 1'b0;
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				// target arc length
				S_T_MGO: begin
					state_q <= S_T_MWT;
				end
				S_T_MWT: begin
					if (udone) begin
						prod_q  <= ures;
						state_q <= S_T_DGO;
					end
				end
				S_T_DGO: begin
					state_q <= S_T_DWT;
				end
				S_T_DWT: begin
					if (udone) begin
						t_q     <= ures[TOT_W-1:0];
						state_q <= S_W_RD;
					end
				end
				// segment walk
				S_W_RD: begin
					state_q <= S_W_CHK;
				end
				S_W_CHK: begin
					if (walk_more && (len_ext < gap)) begin
						sofar_q <= sofar_q + len_ext;
						seg_q   <= seg_q + 1'b1;
						state_q <= S_W_RD;
					end else begin
						len_q   <= sl_rd_q;
						ib_q    <= (gap > len_ext) ? sl_rd_q : gap[plr_pkg::LEN_W-1:0];
						state_q <= S_RDA;
					end
				end
				// placement of one coordinate
				S_PL_MGO: begin
					if (len_q == '0) begin
						e_q[k_q] <= pa_q[k_q];
						if (k_q == 2'd2) begin
							elast_q <= 1'b0;
							state_q <= S_EMIT;
						end else begin
							k_q <= k_q + 1'b1;
						end
					end else begin
						state_q <= S_PL_MWT;
					end
				end
				S_PL_MWT: begin
					if (udone) begin
						prod_q  <= ures;
						state_q <= S_PL_DGO;
					end
				end
				S_PL_DGO: begin
					state_q <= S_PL_DWT;
				end
				S_PL_DWT: begin
					if (udone) begin
						e_q[k_q] <= placed;
						if (k_q == 2'd2) begin
							elast_q <= 1'b0;
							state_q <= S_EMIT;
						end else begin
							k_q     <= k_q + 1'b1;
							state_q <= S_PL_MGO;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			out_data_q   <= '0;
			out_last_q   <= 1'b0;
			out_status_q <= plr_pkg::ST_OK;
		end else begin
			if (m_axis_tready)
				out_valid_q <= 1'b0;
			if ((state_q == S_EMIT) && !out_valid_q) begin
				out_valid_q  <= 1'b1;
				out_data_q   <= {e_q[2], e_q[1], e_q[0]};
				out_last_q   <= elast_q;
				out_status_q <= status_q;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tuser  = out_status_q;

`ifndef SYNTH
	// the point count never passes the store depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_POINTS))
		else $error("point count beyond store depth");

	// unit results only arrive while the sequencer waits for them
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		udone |-> (state_q == S_SQ_WT || state_q == S_RT_WT || state_q == S_T_MWT ||
			state_q == S_T_DWT || state_q == S_PL_MWT || state_q == S_PL_DWT))
		else $error("unit result outside a wait state");
`endif

endmodule

// ----- tb/tb_polyline_arc_length_resampler_top.sv -----
// self-checking testbench of polyline_arc_length_resampler_top: streams polylines in,
// predicts every resampled point and compares it field by field on the output stream
// depends on plr_pkg and polyline_arc_length_resampler_top
module tb_polyline_arc_length_resampler_top;

	localparam int NPTS = 64;

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic        fin;
	} point_t;

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic        last;
		logic [1:0]  st;
	} sample_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [5:0]  cfg_wdata;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [95:0] s_axis_tdata;
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [95:0] m_axis_tdata;
	logic        m_axis_tlast;
	logic [1:0]  m_axis_tuser;

	polyline_arc_length_resampler_top i_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
		.m_axis_tuser(m_axis_tuser)
	);

	// predictor state
	logic signed [63:0] px [NPTS];
	logic signed [63:0] py [NPTS];
	logic signed [63:0] pz [NPTS];
	logic [63:0]        seglen [NPTS];
	int unsigned        npts_held;
	bit                 dropped;
	logic [5:0]         interior_cfg;

	point_t  pending_points [$];
	sample_t expected_samples [$];
	int      errors;
	bit      idle_free;
	bit      hold_out;
	bit      hold_request;
	longint  cycle_count;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// integer square root, floor
	function automatic logic [63:0] isqrt(logic [127:0] v);
		logic [63:0]  r;
		logic [63:0]  c;
		r = 0;
		for (int b = 36; b >= 0; b--) begin
			c = r | (64'd1 << b);
			if (128'(c) * 128'(c) <= v) r = c;
		end
		return r;
	endfunction

	function automatic logic signed [63:0] lerp_coord(logic signed [63:0] a,
			logic signed [63:0] b, logic [63:0] ib, logic [63:0] len);
		logic signed [63:0] d;
		logic [127:0]       mag;
		logic [127:0]       q;
		if (len == 0) return a;
		d = b - a;
		mag = (d < 0) ? 128'(-d) : 128'(d);
		q = (mag * 128'(ib)) / 128'(len);
		return (d < 0) ? a - 64'(q) : a + 64'(q);
	endfunction

	// accept one point and queue whatever results the polyline produces
	task automatic predict_point(point_t p);
		int unsigned        n;
		int unsigned        newp;
		int unsigned        seg;
		logic [1:0]         st;
		logic [63:0]        total;
		logic [63:0]        sofar;
		logic [63:0]        tgt;
		logic [63:0]        ib;
		logic signed [63:0] dx;
		logic signed [63:0] dy;
		logic signed [63:0] dz;
		sample_t            s;
		if (npts_held < NPTS) begin
			px[npts_held] = 64'(signed'(p.x));
			py[npts_held] = 64'(signed'(p.y));
			pz[npts_held] = 64'(signed'(p.z));
			npts_held++;
		end else begin
			dropped = 1;
		end
		if (!p.fin) return;
		n = npts_held;
		st = dropped ? plr_pkg::ST_OVF : plr_pkg::ST_OK;
		npts_held = 0;
		dropped = 0;
		if (n < 2) begin
			s = '{x: 0, y: 0, z: 0, last: 1'b1, st: plr_pkg::ST_SHORT};
			expected_samples.push_back(s);
			return;
		end
		newp = (interior_cfg > plr_pkg::MAX_INTERIOR) ? plr_pkg::MAX_INTERIOR : interior_cfg;
		total = 0;
		for (int i = 0; i + 1 < n; i++) begin
			dx = px[i+1] - px[i];
			dy = py[i+1] - py[i];
			dz = pz[i+1] - pz[i];
			seglen[i] = isqrt(128'(dx) * 128'(dx) + 128'(dy) * 128'(dy) +
				128'(dz) * 128'(dz));
			total += seglen[i];
		end
		s = '{x: px[0][31:0], y: py[0][31:0], z: pz[0][31:0], last: 1'b0, st: st};
		expected_samples.push_back(s);
		seg = 0;
		sofar = 0;
		for (int j = 1; j <= newp; j++) begin
			tgt = 64'((128'(total) * j) / (newp + 1));
			while (seg + 2 < n && seglen[seg] < tgt - sofar) begin
				sofar += seglen[seg];
				seg++;
			end
			ib = (tgt > sofar) ? tgt - sofar : 0;
			if (ib > seglen[seg]) ib = seglen[seg];
			s.x = 32'(lerp_coord(px[seg], px[seg+1], ib, seglen[seg]));
			s.y = 32'(lerp_coord(py[seg], py[seg+1], ib, seglen[seg]));
			s.z = 32'(lerp_coord(pz[seg], pz[seg+1], ib, seglen[seg]));
			s.last = 1'b0;
			expected_samples.push_back(s);
		end
		s = '{x: px[n-1][31:0], y: py[n-1][31:0], z: pz[n-1][31:0], last: 1'b1, st: st};
		expected_samples.push_back(s);
	endtask

	function automatic logic [31:0] rand_coord(int mode);
		case (mode)
			0: return 32'($urandom_range(0, 2000)) - 32'd1000;
			1: return $urandom;
			default: return 32'($urandom_range(0, 8000000)) - 32'd4000000;
		endcase
	endfunction

	task automatic add_polyline(int len, int mode);
		point_t p;
		for (int i = 0; i < len; i++) begin
			p.x = rand_coord(mode);
			p.y = rand_coord(mode);
			p.z = rand_coord(mode);
			p.fin = (i == len - 1);
			pending_points.push_back(p);
		end
	endtask

	// wait until the block has returned every result, then let it settle
	task automatic drain();
		while (pending_points.size() != 0 || expected_samples.size() != 0 || s_axis_tvalid)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_interior(logic [5:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		interior_cfg = v;
	endtask

	// driver: offers pending points with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tlast <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				predict_point(pending_points.pop_front());
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_points.size() != 0 && (idle_free || $urandom_range(0, 99) >= 34)) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {pending_points[0].z, pending_points[0].y,
						pending_points[0].x};
					s_axis_tlast <= pending_points[0].fin;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off, counted here
	always @(posedge clk) begin
		if (hold_request && !hold_out) begin
			hold_out <= 1'b1;
			repeat (20000) @(posedge clk);
			hold_out <= 1'b0;
		end
	end

	// monitor: random back-pressure and comparison against predicted samples
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_samples.size() == 0) begin
					$display("%0t: unexpected transaction x=%h y=%h z=%h last=%b status=%0d",
						$time, m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[95:64],
						m_axis_tlast, m_axis_tuser);
					errors++;
				end else begin
					sample_t e;
					e = expected_samples.pop_front();
					if (m_axis_tdata[31:0] !== e.x) begin
						$display("%0t: out_x expected %h actual %h", $time, e.x, m_axis_tdata[31:0]);
						errors++;
					end
					if (m_axis_tdata[63:32] !== e.y) begin
						$display("%0t: out_y expected %h actual %h", $time, e.y, m_axis_tdata[63:32]);
						errors++;
					end
					if (m_axis_tdata[95:64] !== e.z) begin
						$display("%0t: out_z expected %h actual %h", $time, e.z, m_axis_tdata[95:64]);
						errors++;
					end
					if (m_axis_tlast !== e.last) begin
						$display("%0t: end_of_run expected %b actual %b", $time, e.last, m_axis_tlast);
						errors++;
					end
					if (m_axis_tuser !== e.st) begin
						$display("%0t: status expected %0d actual %0d", $time, e.st, m_axis_tuser);
						errors++;
					end
				end
			end
			m_axis_tready <= !hold_out && (idle_free || $urandom_range(0, 99) >= 34);
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 64'd30000000) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		point_t p;
		errors = 0;
		idle_free = 0;
		hold_out = 0;
		hold_request = 0;
		cycle_count = 0;
		npts_held = 0;
		dropped = 0;
		interior_cfg = 6'd1;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: default setting, lone point, extremes, zero-length segments
		p = '{x: 32'h7FFFFFFF, y: 32'h80000000, z: 32'h0, fin: 1'b1};
		pending_points.push_back(p);
		p = '{x: 32'h80000000, y: 32'h80000000, z: 32'h80000000, fin: 1'b0};
		pending_points.push_back(p);
		p = '{x: 32'h7FFFFFFF, y: 32'h7FFFFFFF, z: 32'h7FFFFFFF, fin: 1'b1};
		pending_points.push_back(p);
		p = '{x: 32'h10000, y: 32'h20000, z: 32'hFFFF0000, fin: 1'b0};
		pending_points.push_back(p);
		pending_points.push_back(p);
		p.fin = 1'b1;
		pending_points.push_back(p);
		add_polyline(4, 1);
		drain();

		// no interior points, then the largest settings
		write_interior(6'd0);
		add_polyline(3, 0);
		drain();
		write_interior(6'd63);
		add_polyline(2, 1);
		p = '{x: 0, y: 0, z: 0, fin: 1'b0};
		pending_points.push_back(p);
		pending_points.push_back(p);
		p.fin = 1'b1;
		pending_points.push_back(p);
		drain();
		write_interior(6'd62);
		add_polyline(5, 2);
		drain();

		// overflow of the store with the receiver stalled for a long stretch
		write_interior(6'd3);
		hold_request = 1;
		add_polyline(NPTS + 3, 2);
		add_polyline(3, 0);
		repeat (2) @(posedge clk);
		hold_request = 0;
		drain();

		// random polylines, several settings, one stretch without idling
		for (int phase = 0; phase < 6; phase++) begin
			write_interior((phase == 5) ? 6'd63 : 6'($urandom_range(0, 8)));
			idle_free = (phase == 2);
			for (int k = 0; k < 14; k++)
				add_polyline($urandom_range(1, 8), $urandom_range(0, 2));
			drain();
		end
		idle_free = 0;

		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
